>>> sv/fpts_pkg.sv
// fpts_pkg: shared types and constants for the fixed partition triple stack unit
// holds the transaction structs, operation and status codes and fixed widths
// no dependencies
`default_nettype none

package fpts_pkg;

  localparam int unsigned REGION_DEPTH_DEF = 16;
  localparam int unsigned NUM_STACKS       = 3;
  localparam int unsigned DATA_WIDTH       = 32;
  localparam int unsigned CAP_WIDTH        = 5;
  localparam int unsigned CAP_RESET        = 16;

  // operation codes, an unused code acts as a peek
  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  localparam logic signed [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic [1:0]                   mode;
    logic [1:0]                   stack_sel;
    logic signed [DATA_WIDTH-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] read_value;
    logic [1:0]                   status;
    logic                         now_empty;
    logic                         now_full;
  } out_item_t;

endpackage

`default_nettype wire

>>> sv/fixed_partition_triple_stack_unit.sv
// fixed_partition_triple_stack_unit: three stacks in fixed regions of one memory
// uses fpts_pkg for types and codes and fpts_ram for the entry store
//
// Three stacks share one memory of 3 * REGION_DEPTH entries; stack s lives in
// region s. Each input transaction pushes, pops or peeks one stack and gives
// exactly one result transaction. The unit takes one transaction per cycle while
// the result side keeps up. A result passes through the memory's registered read
// port, addressed from the per-stack count at acceptance, and then the output
// register before it is offered. With the result side stalled the unit holds
// two transactions and then stalls its input. The counts sit in
// flip-flops and are updated at acceptance, so back-to-back transactions on one
// stack see each other without interlock. A pop reads the old top and writes
// zero into it in the same cycle. The capacity register may only be written
// while idle; zero acts as one and a value above REGION_DEPTH acts as
// REGION_DEPTH. No clearing pass is needed after reset.
`default_nettype none

module fixed_partition_triple_stack_unit #(
  parameter int unsigned REGION_DEPTH = fpts_pkg::REGION_DEPTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // request channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire fpts_pkg::in_item_t               in_data_i,
  // result channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output fpts_pkg::out_item_t                   out_data_o,
  // capacity register write
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [fpts_pkg::CAP_WIDTH-1:0]   cfg_data_i
);

  import fpts_pkg::*;

  localparam int unsigned STORE_DEPTH = NUM_STACKS * REGION_DEPTH;
  localparam int unsigned AW   = $clog2(STORE_DEPTH);
  localparam int unsigned CW   = $clog2(REGION_DEPTH + 1);
  localparam int unsigned CMPW = (CW > CAP_WIDTH) ? CW : CAP_WIDTH;
  localparam int unsigned SW   = $clog2(NUM_STACKS);

  // capacity register, always writable
  logic [CAP_WIDTH-1:0] cap_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_WIDTH'(CAP_RESET);
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // clamped capacity
  logic [CMPW-1:0] cap_eff;
  always_comb begin
    cap_eff = CMPW'(cap_q);
    if (cap_q == '0) begin
      cap_eff = CMPW'(1);
    end else if (CMPW'(cap_q) > CMPW'(REGION_DEPTH)) begin
      cap_eff = CMPW'(REGION_DEPTH);
    end
  end

  // handshake between acceptance stage and output register
  logic s1_valid_q, s1_move, in_accept, out_take;
  logic out_valid_q;

  assign out_take   = out_valid_q && !out_stall_i;
  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_accept  = in_valid_i && !in_stall_o;

  // per-stack counts
  logic [CW-1:0] cnt_q [NUM_STACKS];
  logic          sel_ok;
  logic [SW-1:0] sel;
  logic [CW-1:0] cur_cnt, new_cnt;
  logic [AW-1:0] base, top_addr, push_addr;
  logic          is_push, is_pop, cur_empty, cur_full;
  logic          push_ok, pop_ok;
  logic [1:0]    status;
  logic          use_rd, rv_neg;

  assign sel     = in_data_i.stack_sel[SW-1:0];
  assign sel_ok  = (32'(in_data_i.stack_sel) < NUM_STACKS);
  assign cur_cnt = sel_ok ? cnt_q[sel] : '0;
  assign is_push = (in_data_i.mode == MODE_PUSH);
  assign is_pop  = (in_data_i.mode == MODE_POP);

  // region base from the stack number, no multiplier needed
  always_comb begin
    case (in_data_i.stack_sel)
      2'd1:    base = AW'(REGION_DEPTH);
      2'd2:    base = AW'(2 * REGION_DEPTH);
      default: base = '0;
    endcase
  end

  assign push_addr = base + AW'(cur_cnt);
  assign top_addr  = push_addr - AW'(1);
  assign cur_empty = (cur_cnt == '0);
  assign cur_full  = (CMPW'(cur_cnt) >= cap_eff);
  assign push_ok   = sel_ok && is_push && !cur_full;
  assign pop_ok    = sel_ok && is_pop && !cur_empty;

  always_comb begin
    new_cnt = cur_cnt;
    if (push_ok) begin
      new_cnt = cur_cnt + CW'(1);
    end else if (pop_ok) begin
      new_cnt = cur_cnt - CW'(1);
    end
  end

  // result classification at acceptance
  always_comb begin
    status = ST_OK;
    use_rd = 1'b0;
    rv_neg = 1'b0;
    if (!sel_ok) begin
      status = ST_INVALID;
      rv_neg = 1'b1;
    end else if (is_push) begin
      if (cur_full) begin
        status = ST_FULL;
      end
    end else if (cur_empty) begin
      status = ST_EMPTY;
      rv_neg = 1'b1;
    end else begin
      use_rd = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (in_accept && sel_ok) begin
      cnt_q[sel] <= new_cnt;
    end
  end

  // entry store: push writes the new top, pop clears the old top
  logic [DATA_WIDTH-1:0] rd_data;

  fpts_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_accept && (push_ok || pop_ok)),
    .waddr_i (push_ok ? push_addr : top_addr),
    .wdata_i (push_ok ? in_data_i.push_value : '0),
    .re_i    (in_accept && use_rd),
    .raddr_i (top_addr),
    .rdata_o (rd_data)
  );

  // stage one: waits for the read data
  logic       s1_use_rd_q, s1_neg_q, s1_empty_q, s1_full_q;
  logic [1:0] s1_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_use_rd_q <= use_rd;
      s1_neg_q    <= rv_neg;
      s1_status_q <= status;
      s1_empty_q  <= sel_ok && (new_cnt == '0);
      s1_full_q   <= sel_ok && (CMPW'(new_cnt) >= cap_eff);
    end
  end

  // output register
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q.read_value <= s1_use_rd_q ? rd_data : (s1_neg_q ? MOST_NEG : '0);
      out_q.status     <= s1_status_q;
      out_q.now_empty  <= s1_empty_q;
      out_q.now_full   <= s1_full_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> sv/fpts_ram.sv
// fpts_ram: generic memory, one write port and one read port
// registered read with read enable, a read and write to one address return old data
// no dependencies
`default_nettype none

module fpts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/fpts_checker.sv
// fpts_checker: port-level assertions for fixed_partition_triple_stack_unit
// uses fpts_pkg for codes and types, bound to the top level at the end of the file
`default_nettype none

module fpts_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire fpts_pkg::out_item_t            out_data_o
);

  import fpts_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // invalid stack: most negative value and no flags
  a_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_INVALID) |->
      (out_data_o.read_value == MOST_NEG) && !out_data_o.now_empty && !out_data_o.now_full)
    else $error("invalid stack result malformed");

  // rejected push leaves the stack full
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_FULL) |->
      out_data_o.now_full && (out_data_o.read_value == '0))
    else $error("full rejection malformed");

  // empty read reports an empty stack
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_EMPTY) |->
      out_data_o.now_empty && (out_data_o.read_value == MOST_NEG))
    else $error("empty result malformed");

endmodule

bind fixed_partition_triple_stack_unit fpts_checker u_fpts_checker (.*);

`default_nettype wire

>>> tb/sv/tb_fixed_partition_triple_stack_unit.sv
// tb_fixed_partition_triple_stack_unit: self-checking testbench for the triple stack unit
// predicts every result from its own copy of the stacks and compares each field
// depends on fpts_pkg and fixed_partition_triple_stack_unit
`default_nettype none

module tb_fixed_partition_triple_stack_unit;

  import fpts_pkg::*;

  // codes the package leaves unnamed: the spare mode behaves as a peek,
  // and stack select 3 names no stack
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0] STACK_NONE = 2'd3;

  localparam logic signed [DATA_WIDTH-1:0] MOST_POS = ~MOST_NEG;
  localparam logic signed [DATA_WIDTH-1:0] ALL_ONES = {DATA_WIDTH{1'b1}};

  localparam int unsigned STORE_DEPTH = NUM_STACKS * REGION_DEPTH_DEF;
  // slowest honest run is roughly 1200 transactions plus the hold-off,
  // so this leaves a wide margin
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 100;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_item_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_item_t            out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CAP_WIDTH-1:0] cfg_data_i  = '0;

  // shared between the stimulus and the result side
  bit          idling_on     = 1'b1;
  int unsigned hold_off_left = 0;
  bit          offering      = 1'b0;
  int unsigned error_count   = 0;
  int unsigned result_count  = 0;
  int unsigned cycle_count   = 0;

  // predicted view of the block
  logic [DATA_WIDTH-1:0] entry_model [STORE_DEPTH];
  int unsigned           depth_model [NUM_STACKS] = '{default: 0};
  logic [CAP_WIDTH-1:0]  capacity_model = CAP_RESET;
  out_item_t             awaited_results [$];

  fixed_partition_triple_stack_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin : clock_gen
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // applies one request to the modelled stacks and returns the result it gives
  function automatic out_item_t predict_stack_op(input in_item_t req);
    out_item_t   res;
    int unsigned cap;
    int unsigned cnt;
    int unsigned base;
    res.read_value = '0;
    res.status     = ST_OK;
    res.now_empty  = 1'b0;
    res.now_full   = 1'b0;
    // zero behaves as one, anything past the region depth is clipped to it
    cap = (capacity_model == 0) ? 1 : capacity_model;
    if (cap > REGION_DEPTH_DEF) cap = REGION_DEPTH_DEF;
    // no such stack: nothing changes and both flags stay low
    if (req.stack_sel >= NUM_STACKS) begin
      res.read_value = MOST_NEG;
      res.status     = ST_INVALID;
      return res;
    end
    base = req.stack_sel * REGION_DEPTH_DEF;
    cnt  = depth_model[req.stack_sel];
    if (req.mode == MODE_PUSH) begin
      // a count above a lowered capacity also counts as full
      if (cnt >= cap) begin
        res.status = ST_FULL;
      end else begin
        entry_model[base + cnt]     = req.push_value;
        depth_model[req.stack_sel] = cnt + 1;
      end
    end else if (cnt == 0) begin
      res.read_value = MOST_NEG;
      res.status     = ST_EMPTY;
    end else begin
      // pop, peek and the spare mode all read the top entry
      res.read_value = entry_model[base + cnt - 1];
      if (req.mode == MODE_POP) begin
        entry_model[base + cnt - 1] = '0;
        depth_model[req.stack_sel] = cnt - 1;
      end
    end
    cnt           = depth_model[req.stack_sel];
    res.now_empty = (cnt == 0);
    res.now_full  = (cnt >= cap);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [DATA_WIDTH-1:0] got,
                                 input logic [DATA_WIDTH-1:0] want);
    if (error_count < MAX_REPORTS)
      $display("result %0d %s: got %h, expected %h", result_count, what, got, want);
    error_count++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    result_count++;
    if (awaited_results.size() == 0) begin
      report_mismatch("arrived with nothing awaited", got.read_value, '0);
      return;
    end
    want = awaited_results.pop_front();
    if (got.read_value !== want.read_value)
      report_mismatch("read_value", got.read_value, want.read_value);
    if (got.status !== want.status)
      report_mismatch("status", got.status, want.status);
    if (got.now_empty !== want.now_empty)
      report_mismatch("now_empty", got.now_empty, want.now_empty);
    if (got.now_full !== want.now_full)
      report_mismatch("now_full", got.now_full, want.now_full);
  endtask

  // one process sees every handshake, register write first, then the request,
  // then the result, so ordering holds even if a result left in the same cycle
  always @(posedge clk_i) begin : result_monitor
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) capacity_model = cfg_data_i;
      if (in_valid_i && !in_stall_o) awaited_results.push_back(predict_stack_op(in_data_i));
      if (out_valid_o && !out_stall_i) check_result(out_data_o);
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random stalls per transaction plus an optional long hold-off
  // ---------------------------------------------------------------------------

  // hold_off_left is only ever set on a falling edge, so there is no race here
  initial begin : result_sink
    int unsigned wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) wait_left = idling_on ? $urandom_range(0, 8) : 0;
      if (hold_off_left != 0) begin
        hold_off_left--;
        out_stall_i <= 1'b1;
      end else if (wait_left != 0) begin
        wait_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_fixed_partition_triple_stack_unit: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // valid is left high after acceptance so back-to-back transactions never
  // drop it; it only falls when a gap is drawn or the sender goes idle
  task automatic send_request(input in_item_t req);
    int unsigned gap;
    gap = idling_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      if (offering) begin
        in_valid_i <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    offering = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_op(input logic [1:0] mode, input logic [1:0] sel,
                         input logic signed [DATA_WIDTH-1:0] value);
    in_item_t req;
    req.mode       = mode;
    req.stack_sel  = sel;
    req.push_value = value;
    send_request(req);
  endtask

  // the extra edge keeps a drop of valid and a later raise in separate steps
  task automatic idle_requests;
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk_i);
  endtask

  // sender pause until every awaited result is back; each request gives
  // exactly one result, so an empty queue means the block is idle
  task automatic wait_results_drained;
    idle_requests();
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_WIDTH-1:0] value);
    wait_results_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // push_pct steers fill versus drain; extremes of the value show up often
  function automatic in_item_t random_request(input int unsigned push_pct);
    in_item_t req;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      req.mode = MODE_PUSH;
    end else begin
      roll = $urandom_range(0, 9);
      if (roll < 7)      req.mode = MODE_POP;
      else if (roll < 9) req.mode = MODE_PEEK;
      else               req.mode = MODE_SPARE;
    end
    req.stack_sel = ($urandom_range(0, 19) == 0) ? STACK_NONE
                                                 : 2'($urandom_range(0, NUM_STACKS - 1));
    case ($urandom_range(0, 7))
      0:       req.push_value = MOST_NEG;
      1:       req.push_value = MOST_POS;
      2:       req.push_value = '0;
      3:       req.push_value = ALL_ONES;
      default: req.push_value = $urandom;
    endcase
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset capacity: empty reads, the spare mode, a missing stack, value extremes
  task automatic test_directed_edges;
    send_op(MODE_PEEK,  2'd0, '0);
    send_op(MODE_POP,   2'd1, '0);
    send_op(MODE_SPARE, 2'd2, '0);
    send_op(MODE_PUSH,  STACK_NONE, MOST_POS);
    send_op(MODE_POP,   STACK_NONE, '0);
    send_op(MODE_PEEK,  STACK_NONE, '0);
    send_op(MODE_SPARE, STACK_NONE, '0);
    send_op(MODE_PUSH,  2'd0, MOST_NEG);
    send_op(MODE_PUSH,  2'd0, MOST_POS);
    send_op(MODE_PUSH,  2'd1, '0);
    send_op(MODE_PUSH,  2'd2, ALL_ONES);
    send_op(MODE_PEEK,  2'd0, '0);
    send_op(MODE_SPARE, 2'd0, '0);
    send_op(MODE_POP,   2'd0, ALL_ONES);
    send_op(MODE_POP,   2'd0, '0);
    send_op(MODE_POP,   2'd0, '0);
    send_op(MODE_POP,   2'd1, '0);
    send_op(MODE_PEEK,  2'd2, '0);
    send_op(MODE_POP,   2'd2, '0);
    send_op(MODE_PEEK,  2'd2, '0);
  endtask

  // capacity zero, above the region depth, and lowered below a live count
  task automatic test_capacity_limits;
    write_capacity(5'd0);
    send_op(MODE_PUSH, 2'd1, $urandom);
    send_op(MODE_PUSH, 2'd1, $urandom);
    send_op(MODE_PEEK, 2'd1, '0);
    send_op(MODE_POP,  2'd1, '0);
    send_op(MODE_POP,  2'd1, '0);

    // 31 clips to the region depth, so the seventeenth push is refused
    write_capacity(5'd31);
    repeat (REGION_DEPTH_DEF + 1) send_op(MODE_PUSH, 2'd2, $urandom);
    repeat (REGION_DEPTH_DEF + 1) send_op(MODE_POP,  2'd2, '0);

    write_capacity(5'd16);
    repeat (6) send_op(MODE_PUSH, 2'd0, $urandom);
    // lowered under the count: stays full while pops work as usual
    write_capacity(5'd2);
    send_op(MODE_PUSH, 2'd0, $urandom);
    send_op(MODE_PEEK, 2'd0, '0);
    repeat (7) send_op(MODE_POP, 2'd0, '0);

    write_capacity(5'd17);
    repeat (REGION_DEPTH_DEF + 1) send_op(MODE_PUSH, 2'd1, $urandom);
    send_op(MODE_PUSH, 2'd0, $urandom);
  endtask

  // long receiver hold-off with the sender pushing on, so the block fills
  // and stalls its input; then the sender waits for every result
  task automatic test_backpressure;
    wait_results_drained();
    idling_on = 1'b0;
    @(negedge clk_i);
    hold_off_left = 300;
    @(posedge clk_i);
    repeat (80) send_request(random_request(50));
    wait_results_drained();
    idling_on = 1'b1;
  endtask

  // phases of random traffic, each under its own capacity; every phase
  // first fills then drains so full and empty both come up
  task automatic test_random_traffic;
    logic [CAP_WIDTH-1:0] caps [10];
    caps = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd17, 5'd3, 5'd8, 5'd16, 5'd2, 5'd31};
    caps[6] = 5'($urandom_range(0, 31));
    caps[7] = 5'($urandom_range(0, 31));
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      // every third phase runs flat out on both sides
      idling_on = (p % 3 != 2);
      repeat (50) send_request(random_request(65));
      repeat (50) send_request(random_request(35));
    end
    idling_on = 1'b1;
  endtask

  initial begin : test_sequence
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed_edges();
    test_capacity_limits();
    test_backpressure();
    test_random_traffic();

    wait_results_drained();
    // a short settle catches any stray result
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_fixed_partition_triple_stack_unit: clean");
    end else begin
      $display("tb_fixed_partition_triple_stack_unit: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
